// ----- rtl/lpcm_pkg.sv -----
package lpcm_pkg;

  localparam int unsigned FIX_FRAC = 32;
  localparam logic [31:0] LIMIT_RESET = 32'd4295;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN1,
    ST_DEN2,
    ST_CHECK,
    ST_NUM1,
    ST_NUM2,
    ST_MUA,
    ST_MUBM,
    ST_MUBD,
    ST_MIDA,
    ST_MIDB,
    ST_MIDR,
    ST_OUT
  } back_state_t;

endpackage

// ----- rtl/lpcm_if.sv -----
interface lpcm_pair_if #(parameter int CW = 24);
  logic valid;
  logic ready;
  logic signed [CW-1:0] a0_x, a0_y, a0_z;
  logic signed [CW-1:0] a1_x, a1_y, a1_z;
  logic signed [CW-1:0] b0_x, b0_y, b0_z;
  logic signed [CW-1:0] b1_x, b1_y, b1_z;

  modport source (
    output valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
    output b0_x, b0_y, b0_z, b1_x, b1_y, b1_z,
    input ready
  );
  modport sink (
    input valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
    input b0_x, b0_y, b0_z, b1_x, b1_y, b1_z,
    output ready
  );
endinterface

interface lpcm_mid_if #(parameter int CW = 24);
  logic valid;
  logic ready;
  logic signed [CW-1:0] mid_x, mid_y, mid_z;
  logic is_parallel;
  logic saturated;

  modport source (
    output valid, mid_x, mid_y, mid_z, is_parallel, saturated,
    input ready
  );
  modport sink (
    input valid, mid_x, mid_y, mid_z, is_parallel, saturated,
    output ready
  );
endinterface

// ----- rtl/lpcm_front.sv -----
module lpcm_front #(
  parameter int CW = 24,
  localparam int PR = 2 * CW + 2,
  localparam int DW = 2 * CW + 3,
  localparam int PW = 5 * DW + 9 * (CW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  lpcm_pair_if.sink     lines,
  output logic          push,
  output logic [PW-1:0] word,
  input  logic          full
);

  typedef struct packed {
    logic [DW-1:0]       d1343;
    logic [DW-1:0]       d4321;
    logic [DW-1:0]       d1321;
    logic [DW-1:0]       d4343;
    logic [DW-1:0]       d2121;
    logic [2:0][CW:0]    sab;
    logic [2:0][CW:0]    p21;
    logic [2:0][CW:0]    p43;
  } pair_t;

  logic signed [CW-1:0] a0 [3];
  logic signed [CW-1:0] a1 [3];
  logic signed [CW-1:0] b0 [3];
  logic signed [CW-1:0] b1 [3];

  logic en;
  logic v1, v2, v3;

  logic signed [CW:0] p13_1 [3];
  logic signed [CW:0] p43_1 [3];
  logic signed [CW:0] p21_1 [3];
  logic signed [CW:0] sab_1 [3];

  logic signed [PR-1:0] e13 [3];
  logic signed [PR-1:0] e43 [3];
  logic signed [PR-1:0] e21 [3];

  logic signed [PR-1:0] m1343 [3];
  logic signed [PR-1:0] m4321 [3];
  logic signed [PR-1:0] m1321 [3];
  logic signed [PR-1:0] m4343 [3];
  logic signed [PR-1:0] m2121 [3];
  logic [2:0][CW:0] sab_2, p21_2, p43_2;

  pair_t out3;

  assign a0[0] = lines.a0_x;
  assign a0[1] = lines.a0_y;
  assign a0[2] = lines.a0_z;
  assign a1[0] = lines.a1_x;
  assign a1[1] = lines.a1_y;
  assign a1[2] = lines.a1_z;
  assign b0[0] = lines.b0_x;
  assign b0[1] = lines.b0_y;
  assign b0[2] = lines.b0_z;
  assign b1[0] = lines.b1_x;
  assign b1[1] = lines.b1_y;
  assign b1[2] = lines.b1_z;

  assign en          = !v3 || !full;
  assign lines.ready = en;
  assign push        = v3 && !full;
  assign word        = out3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= lines.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e13[k] = PR'(p13_1[k]);
      e43[k] = PR'(p43_1[k]);
      e21[k] = PR'(p21_1[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p13_1[k] <= (CW+1)'(a0[k]) - (CW+1)'(b0[k]);
        p43_1[k] <= (CW+1)'(b1[k]) - (CW+1)'(b0[k]);
        p21_1[k] <= (CW+1)'(a1[k]) - (CW+1)'(a0[k]);
        sab_1[k] <= (CW+1)'(a0[k]) + (CW+1)'(b0[k]);

        m1343[k] <= e13[k] * e43[k];
        m4321[k] <= e43[k] * e21[k];
        m1321[k] <= e13[k] * e21[k];
        m4343[k] <= e43[k] * e43[k];
        m2121[k] <= e21[k] * e21[k];
        sab_2[k] <= sab_1[k];
        p21_2[k] <= p21_1[k];
        p43_2[k] <= p43_1[k];
      end

      out3.d1343 <= DW'(m1343[0]) + DW'(m1343[1]) + DW'(m1343[2]);
      out3.d4321 <= DW'(m4321[0]) + DW'(m4321[1]) + DW'(m4321[2]);
      out3.d1321 <= DW'(m1321[0]) + DW'(m1321[1]) + DW'(m1321[2]);
      out3.d4343 <= DW'(m4343[0]) + DW'(m4343[1]) + DW'(m4343[2]);
      out3.d2121 <= DW'(m2121[0]) + DW'(m2121[1]) + DW'(m2121[2]);
      out3.sab   <= sab_2;
      out3.p21   <= p21_2;
      out3.p43   <= p43_2;
    end
  end

endmodule

// ----- rtl/lpcm_queue.sv -----
module lpcm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_wr, do_rd;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (do_rd) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

// ----- rtl/lpcm_arith.sv -----
module lpcm_arith import lpcm_pkg::*; #(
  parameter int BW = 210,
  localparam int CNTW = $clog2(BW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  arith_req_t    req,
  input  logic [BW-1:0] a,
  input  logic [BW-1:0] b,
  output arith_sts_t    sts,
  output logic [BW-1:0] res
);

  logic            busy, done, neg;
  arith_op_t       op;
  logic [BW-1:0]   mc, mp, acc, rem;
  logic [CNTW-1:0] cnt;

  logic [BW-1:0] abs_a, abs_b, qr, rdiff;
  logic [BW:0]   rem2;
  logic          ge, rnd;

  assign abs_a = a[BW-1] ? -a : a;
  assign abs_b = b[BW-1] ? -b : b;

  assign rem2  = {rem, mp[BW-1]};
  assign ge    = rem2 >= {1'b0, mc};
  assign rdiff = rem2[BW-1:0] - mc;
  assign rnd   = {rem, 1'b0} >= {1'b0, mc};
  assign qr    = mp + BW'(rnd);

  assign sts.busy = busy;
  assign sts.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= '0;
        rem  <= '0;
        cnt  <= CNTW'(BW);
        if (req.op == OP_MUL) begin
          mc  <= abs_a;
          mp  <= abs_b;
          neg <= a[BW-1] ^ b[BW-1];
        end else begin
          mc  <= b;
          mp  <= abs_a;
          neg <= a[BW-1];
        end
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            if (mp == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
              res  <= neg ? -acc : acc;
            end else begin
              if (mp[0]) begin
                acc <= acc + mc;
              end
              mc <= mc << 1;
              mp <= mp >> 1;
            end
          end
          default: begin
            if (cnt != '0) begin
              rem <= ge ? rdiff : rem2[BW-1:0];
              mp  <= {mp[BW-2:0], ge};
              cnt <= cnt - CNTW'(1);
            end else begin
              busy <= 1'b0;
              done <= 1'b1;
              res  <= neg ? -qr : qr;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/lpcm_back.sv -----
module lpcm_back import lpcm_pkg::*; #(
  parameter int CW = 24,
  localparam int DW = 2 * CW + 3,
  localparam int PW = 5 * DW + 9 * (CW + 1),
  localparam int BW = 7 * CW + 42,
  localparam int QW = BW - 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   limit,
  input  logic          empty,
  output logic          pop,
  input  logic [PW-1:0] word,
  lpcm_mid_if.source    result
);

  typedef struct packed {
    logic [DW-1:0]       d1343;
    logic [DW-1:0]       d4321;
    logic [DW-1:0]       d1321;
    logic [DW-1:0]       d4343;
    logic [DW-1:0]       d2121;
    logic [2:0][CW:0]    sab;
    logic [2:0][CW:0]    p21;
    logic [2:0][CW:0]    p43;
  } pair_t;

  localparam logic [QW-1:0] HALF_Q = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

  pair_t       it;
  back_state_t state, state_next;
  arith_req_t  req;
  arith_sts_t  sts;
  logic [BW-1:0] op_a, op_b, res;

  logic          launched;
  logic [1:0]    k;
  logic [BW-1:0] t, den, mua, mub;
  logic [2:0][CW-1:0] mid;
  logic          par, sat;

  logic          parallel, arith_st, out_fire;
  logic [BW-1:0] mag;
  logic [QW-1:0] q, qn;
  logic [CW-1:0] mv;
  logic          sat_k;

  assign it       = word;
  assign out_fire = !result.valid || result.ready;
  assign parallel = (den == '0) || (den < BW'(limit)) || (it.d4343 == '0);

  lpcm_arith #(.BW(BW)) u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .a   (op_a),
    .b   (op_b),
    .sts (sts),
    .res (res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!empty) state_next = ST_DEN1;
      ST_DEN1:  if (sts.done) state_next = ST_DEN2;
      ST_DEN2:  if (sts.done) state_next = ST_CHECK;
      ST_CHECK: state_next = parallel ? ST_OUT : ST_NUM1;
      ST_NUM1:  if (sts.done) state_next = ST_NUM2;
      ST_NUM2:  if (sts.done) state_next = ST_MUA;
      ST_MUA:   if (sts.done) state_next = ST_MUBM;
      ST_MUBM:  if (sts.done) state_next = ST_MUBD;
      ST_MUBD:  if (sts.done) state_next = ST_MIDA;
      ST_MIDA:  if (sts.done) state_next = ST_MIDB;
      ST_MIDB:  if (sts.done) state_next = ST_MIDR;
      ST_MIDR:  state_next = (k == 2'd2) ? ST_OUT : ST_MIDA;
      ST_OUT:   if (out_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    arith_st = 1'b0;
    req.op   = OP_MUL;
    op_a     = '0;
    op_b     = '0;
    unique case (state)
      ST_IDLE: pop = !empty;
      ST_DEN1: begin
        arith_st = 1'b1;
        op_a     = BW'($signed(it.d2121));
        op_b     = BW'($signed(it.d4343));
      end
      ST_DEN2: begin
        arith_st = 1'b1;
        op_a     = BW'($signed(it.d4321));
        op_b     = BW'($signed(it.d4321));
      end
      ST_NUM1: begin
        arith_st = 1'b1;
        op_a     = BW'($signed(it.d1343));
        op_b     = BW'($signed(it.d4321));
      end
      ST_NUM2: begin
        arith_st = 1'b1;
        op_a     = BW'($signed(it.d1321));
        op_b     = BW'($signed(it.d4343));
      end
      ST_MUA: begin
        arith_st = 1'b1;
        req.op   = OP_DIV;
        op_a     = t << FIX_FRAC;
        op_b     = den;
      end
      ST_MUBM: begin
        arith_st = 1'b1;
        op_a     = mua;
        op_b     = BW'($signed(it.d4321));
      end
      ST_MUBD: begin
        arith_st = 1'b1;
        req.op   = OP_DIV;
        op_a     = t;
        op_b     = BW'($signed(it.d4343));
      end
      ST_MIDA: begin
        arith_st = 1'b1;
        op_a     = mua;
        op_b     = BW'($signed(it.p21[k]));
      end
      ST_MIDB: begin
        arith_st = 1'b1;
        op_a     = mub;
        op_b     = BW'($signed(it.p43[k]));
      end
      default: begin
        arith_st = 1'b0;
      end
    endcase
    req.start = arith_st && !launched;
  end

  always_comb begin
    mag   = t[BW-1] ? -t : t;
    q     = QW'(mag[BW-1:33]) + QW'(mag[32]);
    qn    = ~q + QW'(1);
    sat_k = 1'b0;
    if (t[BW-1]) begin
      if (q > HALF_Q) begin
        sat_k = 1'b1;
        mv    = {1'b1, {(CW-1){1'b0}}};
      end else begin
        mv = qn[CW-1:0];
      end
    end else begin
      if (q > HALF_Q - QW'(1)) begin
        sat_k = 1'b1;
        mv    = {1'b0, {(CW-1){1'b1}}};
      end else begin
        mv = q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      k            <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start) begin
        launched <= 1'b1;
      end else if (sts.done) begin
        launched <= 1'b0;
      end
      if (state == ST_CHECK) begin
        k <= '0;
      end else if (state == ST_MIDR) begin
        k <= k + 2'd1;
      end
      if (state == ST_OUT && out_fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      case (state)
        ST_DEN1: t   <= res;
        ST_DEN2: den <= t - res;
        ST_NUM1: t   <= res;
        ST_NUM2: t   <= t - res;
        ST_MUA:  mua <= res;
        ST_MUBM: t   <= (BW'($signed(it.d1343)) << FIX_FRAC) + res;
        ST_MUBD: mub <= res;
        ST_MIDA: t   <= (BW'($signed(it.sab[k])) << FIX_FRAC) + res;
        ST_MIDB: t   <= t + res;
        default: t   <= t;
      endcase
    end
    if (state == ST_CHECK) begin
      par <= parallel;
      sat <= 1'b0;
      mid <= '0;
    end
    if (state == ST_MIDR) begin
      mid[k] <= mv;
      sat    <= sat | sat_k;
    end
    if (state == ST_OUT && out_fire) begin
      result.mid_x       <= mid[0];
      result.mid_y       <= mid[1];
      result.mid_z       <= mid[2];
      result.is_parallel <= par;
      result.saturated   <= sat;
    end
  end

endmodule

// ----- rtl/line_pair_closest_midpoint.sv -----
// channel  | dir | word
// lines    | in  | a0, a1, b0, b1 points, COORD_WIDTH bits per axis
// result   | out | mid_x/y/z, is_parallel, saturated
// cfg_wr_* | in  | parallel_limit, 32 bits
//
// The front pipeline takes one word per cycle into a QUEUE_DEPTH entry queue and
// stalls only when the queue is full.
// The back end runs one pair at a time through a shared shift-add multiplier
// and restoring divider; each multiply ends once no significant multiplier bits
// remain, and parallel lines skip the numerator and midpoint steps.
// Reset loads parallel_limit with 4295 and empties the queue. The result
// register holds until taken.
module line_pair_closest_midpoint import lpcm_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  lpcm_pair_if.sink   lines,
  lpcm_mid_if.source  result
);

  localparam int DW = 2 * COORD_WIDTH + 3;
  localparam int PW = 5 * DW + 9 * (COORD_WIDTH + 1);

  logic [31:0]   parallel_limit;
  logic          push, full, pop, empty;
  logic [PW-1:0] front_word, queue_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      parallel_limit <= cfg_wr_data;
    end
  end

  lpcm_front #(.CW(COORD_WIDTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .lines (lines),
    .push  (push),
    .word  (front_word),
    .full  (full)
  );

  lpcm_queue #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_word),
    .full    (full),
    .pop     (pop),
    .rd_data (queue_word),
    .empty   (empty)
  );

  lpcm_back #(.CW(COORD_WIDTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .limit  (parallel_limit),
    .empty  (empty),
    .pop    (pop),
    .word   (queue_word),
    .result (result)
  );

endmodule
